// ===== hw/rtl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; every file but the checker imports this package.
package wsd_pkg;

  // Seven-bit length codes that announce an extended length field.
  localparam logic [6:0] LenCode16 = 7'd126;
  localparam logic [6:0] LenCode64 = 7'd127;

  // Byte counts of the extended length fields and of the mask key.
  localparam logic [3:0] ExtLen16Bytes = 4'd2;
  localparam logic [3:0] ExtLen64Bytes = 4'd8;
  localparam logic [3:0] MaskKeyBytes  = 4'd4;

  // One classified result on its way from the parser to the output stage.
  // The key byte is already selected (zero for unmasked or empty frames).
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       fin;
    logic       first;
    logic       last;
    logic       empty;
  } wsd_item_t;

endpackage

// ===== hw/rtl/wsd_parser.sv =====
// Front end of the deframer: header, length and mask key parser.
// Depends on wsd_pkg; pushes one request per payload byte or empty frame.
module wsd_parser
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output wsd_item_t  item_o
);

  typedef enum logic [2:0] {
    PhHdr0    = 3'd0,
    PhHdr1    = 3'd1,
    PhExtLen  = 3'd2,
    PhMask    = 3'd3,
    PhPayload = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        fin_q, fin_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [3:0]  hcnt_q, hcnt_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  pidx_q, pidx_d;

  logic [6:0]  len7;
  logic        do_len_done;
  logic        do_enter;
  logic [7:0]  key_byte;

  assign len7 = rx_byte_i[6:0];

  // Key byte for the current payload position; the first key byte received
  // sits in the top byte of the key register.
  always_comb begin
    unique case (pidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Next-state logic of the parser for one accepted byte.
  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    fin_d       = fin_q;
    mask_d      = mask_q;
    len_d       = len_q;
    hcnt_d      = hcnt_q;
    key_d       = key_q;
    pidx_d      = pidx_q;
    do_len_done = 1'b0;
    do_enter    = 1'b0;
    push_o      = 1'b0;

    item_o.data   = rx_byte_i;
    item_o.key    = mask_q ? key_byte : 8'h00;
    item_o.opcode = opcode_q;
    item_o.fin    = fin_q;
    item_o.first  = (hcnt_q != 4'd0);
    item_o.last   = (len_q == 64'd1);
    item_o.empty  = 1'b0;

    if (accept_i) begin
      unique case (phase_q)
        PhHdr1: begin
          mask_d = rx_byte_i[7];
          if (len7 == LenCode16) begin
            len_d   = 64'd0;
            hcnt_d  = ExtLen16Bytes;
            phase_d = PhExtLen;
          end else if (len7 == LenCode64) begin
            len_d   = 64'd0;
            hcnt_d  = ExtLen64Bytes;
            phase_d = PhExtLen;
          end else begin
            len_d       = {57'd0, len7};
            do_len_done = 1'b1;
          end
        end
        PhExtLen: begin
          len_d  = {len_q[55:0], rx_byte_i};
          hcnt_d = hcnt_q - 4'd1;
          if (hcnt_q == 4'd1) begin
            do_len_done = 1'b1;
          end
        end
        PhMask: begin
          key_d  = {key_q[23:0], rx_byte_i};
          hcnt_d = hcnt_q - 4'd1;
          if (hcnt_q == 4'd1) begin
            do_enter = 1'b1;
          end
        end
        PhPayload: begin
          push_o = 1'b1;
          hcnt_d = 4'd0;
          pidx_d = pidx_q + 2'd1;
          len_d  = len_q - 64'd1;
          if (len_q == 64'd1) begin
            phase_d = PhHdr0;
          end
        end
        default: begin
          fin_d    = rx_byte_i[7];
          opcode_d = rx_byte_i[3:0];
          phase_d  = PhHdr1;
        end
      endcase

      // Length complete: fetch the key if masked, else start the body.
      if (do_len_done) begin
        if (mask_d) begin
          phase_d = PhMask;
          hcnt_d  = MaskKeyBytes;
          key_d   = 32'd0;
        end else begin
          do_enter = 1'b1;
        end
      end

      // Body start: a zero length frame yields a single empty result.
      if (do_enter) begin
        pidx_d = 2'd0;
        if (len_d == 64'd0) begin
          push_o       = 1'b1;
          item_o.data  = 8'h00;
          item_o.key   = 8'h00;
          item_o.first = 1'b1;
          item_o.last  = 1'b1;
          item_o.empty = 1'b1;
          phase_d      = PhHdr0;
        end else begin
          phase_d = PhPayload;
          hcnt_d  = 4'd1;
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr0;
      opcode_q <= 4'd0;
      fin_q    <= 1'b0;
      mask_q   <= 1'b0;
      len_q    <= 64'd0;
      hcnt_q   <= 4'd0;
      key_q    <= 32'd0;
      pidx_q   <= 2'd0;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      fin_q    <= fin_d;
      mask_q   <= mask_d;
      len_q    <= len_d;
      hcnt_q   <= hcnt_d;
      key_q    <= key_d;
      pidx_q   <= pidx_d;
    end
  end

endmodule

// ===== hw/rtl/wsd_fifo.sv =====
// Short request queue between the parser and the output stage.
// Depends on wsd_pkg for the queued item type.
module wsd_fifo
  import wsd_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  wsd_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output wsd_item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  wsd_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, rptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/wsd_emit.sv =====
// Back end of the deframer: unmasks queued requests into the output register.
// Depends on wsd_pkg for the queued item type.
module wsd_emit
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  wsd_item_t  q_item_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic [3:0] frame_opcode_o,
  output logic       final_fragment_o,
  output logic       first_of_frame_o,
  output logic       last_of_frame_o,
  output logic       empty_frame_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic [3:0] opcode_q;
  logic       fin_q, first_q, last_q, empty_q;

  // Take the next request whenever the output register is free or draining.
  assign q_pop_o = q_valid_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= q_valid_i;
    end
  end

  // Output payload register; the XOR removes the mask.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      data_q   <= q_item_i.data ^ q_item_i.key;
      opcode_q <= q_item_i.opcode;
      fin_q    <= q_item_i.fin;
      first_q  <= q_item_i.first;
      last_q   <= q_item_i.last;
      empty_q  <= q_item_i.empty;
    end
  end

  assign out_valid_o      = valid_q;
  assign payload_byte_o   = data_q;
  assign frame_opcode_o   = opcode_q;
  assign final_fragment_o = fin_q;
  assign first_of_frame_o = first_q;
  assign last_of_frame_o  = last_q;
  assign empty_frame_o    = empty_q;

endmodule

// ===== hw/rtl/websocket_frame_deframer_unit.sv =====
// WebSocket (RFC 6455) receive deframer, top level. Takes one received byte per
// accepted request and returns one result per payload byte, unmasked and tagged
// with opcode, FIN and first/last marks, or a single empty-marked result for a
// frame of zero length; header, length and key bytes return nothing. The block
// accepts one byte every cycle while the output side keeps up. Each result is
// written into the request queue and moves from there to the output register.
// Backpressure reaches the input once the queue of QueueDepth entries and the
// output register are all occupied.
// Depends on wsd_pkg, wsd_parser, wsd_fifo and wsd_emit.
module websocket_frame_deframer_unit
  import wsd_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] payload_byte_o,
  output logic [3:0] frame_opcode_o,
  output logic       final_fragment_o,
  output logic       first_of_frame_o,
  output logic       last_of_frame_o,
  output logic       empty_frame_o
);

  logic      accept;
  logic      push;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  wsd_item_t push_item;
  wsd_item_t head_item;

  // A byte is taken only when the queue has room for its possible result.
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  wsd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .item_o    (push_item)
  );

  wsd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  wsd_emit u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (head_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .payload_byte_o   (payload_byte_o),
    .frame_opcode_o   (frame_opcode_o),
    .final_fragment_o (final_fragment_o),
    .first_of_frame_o (first_of_frame_o),
    .last_of_frame_o  (last_of_frame_o),
    .empty_frame_o    (empty_frame_o)
  );

endmodule

// ===== hw/rtl/wsd_checker.sv =====
// Port-level checks for the WebSocket deframer, bound to the top level.
// Depends only on the top level's ports.
module wsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] payload_byte_o,
  input logic [3:0] frame_opcode_o,
  input logic       final_fragment_o,
  input logic       first_of_frame_o,
  input logic       last_of_frame_o,
  input logic       empty_frame_o
);

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_byte_o)
      && $stable(frame_opcode_o) && $stable(last_of_frame_o))
    else $error("stalled result changed");

  // An empty frame result is a whole frame with a zero data byte.
  a_empty_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_frame_o |->
      first_of_frame_o && last_of_frame_o && (payload_byte_o == 8'h00))
    else $error("empty frame result has wrong marks");

  // With the output register free the queue cannot be full.
  a_ready_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output is empty");

  // A result taken that is not the last of its frame is followed by one that is not
  // first and keeps opcode and FIN, if a result is valid in the following cycle.
  a_frame_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_of_frame_o ##1 out_valid_o |->
      !first_of_frame_o && (frame_opcode_o == $past(frame_opcode_o))
      && (final_fragment_o == $past(final_fragment_o)))
    else $error("frame header changed inside a frame");

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (.*);

// ===== test/tb_websocket_frame_deframer_unit.sv =====
// Self-checking testbench for the WebSocket receive deframer top level.
// Depends on wsd_pkg and websocket_frame_deframer_unit; it predicts every result
// from the accepted byte stream and checks the results in order.
module tb_websocket_frame_deframer_unit
  import wsd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 1100;
  localparam int unsigned TailItems   = 150;
  localparam int unsigned CycleLimit  = 400_000;
  localparam int unsigned DrainCycles = 20;

  // Parser phases of the deframer.
  typedef enum logic [2:0] {
    PhHeader0 = 3'd0,
    PhHeader1 = 3'd1,
    PhExtLen  = 3'd2,
    PhMaskKey = 3'd3,
    PhPayload = 3'd4
  } deframe_phase_e;

  // Length field forms in a generated frame header.
  typedef enum int {
    LenShort = 0,
    LenExt16 = 1,
    LenExt64 = 2
  } len_form_e;

  typedef struct {
    deframe_phase_e phase;
    logic [3:0]     opcode;
    logic           fin;
    logic           masked;
    logic [63:0]    remaining;
    logic [3:0]     bytes_due;
    logic [31:0]    key;
    logic [1:0]     key_idx;
  } deframe_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] opcode;
    logic       fin;
    logic       first;
    logic       last;
    logic       empty;
  } frame_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] payload_byte_o;
  logic [3:0] frame_opcode_o;
  logic       final_fragment_o;
  logic       first_of_frame_o;
  logic       last_of_frame_o;
  logic       empty_frame_o;

  logic [7:0]     stream_bytes_q[$];
  frame_result_t  awaited_results_q[$];
  deframe_state_t rx_parser;
  deframe_state_t gen_parser;

  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned empty_count = 0;
  int unsigned frames_queued = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;

  websocket_frame_deframer_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .payload_byte_o   (payload_byte_o),
    .frame_opcode_o   (frame_opcode_o),
    .final_fragment_o (final_fragment_o),
    .first_of_frame_o (first_of_frame_o),
    .last_of_frame_o  (last_of_frame_o),
    .empty_frame_o    (empty_frame_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic deframe_state_t parser_at_reset();
    deframe_state_t st;
    st.phase     = PhHeader0;
    st.opcode    = '0;
    st.fin       = 1'b0;
    st.masked    = 1'b0;
    st.remaining = '0;
    st.bytes_due = '0;
    st.key       = '0;
    st.key_idx   = '0;
    return st;
  endfunction

  // Advances the parser by one received byte; returns 1 when a result comes out.
  function automatic logic deframe_byte(inout deframe_state_t st, input logic [7:0] b,
                                        output frame_result_t res);
    logic length_known;
    logic body_start;
    logic emit;
    length_known = 1'b0;
    body_start   = 1'b0;
    emit         = 1'b0;
    res          = '0;
    case (st.phase)
      PhHeader1: begin
        st.masked = b[7];
        if (b[6:0] == LenCode16) begin
          st.remaining = '0;
          st.bytes_due = ExtLen16Bytes;
          st.phase     = PhExtLen;
        end else if (b[6:0] == LenCode64) begin
          st.remaining = '0;
          st.bytes_due = ExtLen64Bytes;
          st.phase     = PhExtLen;
        end else begin
          st.remaining = 64'(b[6:0]);
          length_known = 1'b1;
        end
      end
      PhExtLen: begin
        st.remaining = {st.remaining[55:0], b};
        st.bytes_due = st.bytes_due - 4'd1;
        length_known = (st.bytes_due == 4'd0);
      end
      PhMaskKey: begin
        st.key       = {st.key[23:0], b};
        st.bytes_due = st.bytes_due - 4'd1;
        body_start   = (st.bytes_due == 4'd0);
      end
      PhPayload: begin
        res.data   = st.masked ? (b ^ st.key[8 * (3 - int'(st.key_idx)) +: 8]) : b;
        res.opcode = st.opcode;
        res.fin    = st.fin;
        res.first  = (st.bytes_due != 4'd0);
        res.last   = (st.remaining == 64'd1);
        res.empty  = 1'b0;
        emit         = 1'b1;
        st.bytes_due = '0;
        st.key_idx   = st.key_idx + 2'd1;
        st.remaining = st.remaining - 64'd1;
        if (res.last) begin
          st.phase = PhHeader0;
        end
      end
      default: begin
        st.fin    = b[7];
        st.opcode = b[3:0];
        st.phase  = PhHeader1;
      end
    endcase

    // A finished length leads to the mask key, or straight to the payload.
    if (length_known) begin
      if (st.masked) begin
        st.phase     = PhMaskKey;
        st.bytes_due = MaskKeyBytes;
        st.key       = '0;
      end else begin
        body_start = 1'b1;
      end
    end

    // A zero-length frame yields one empty-marked result on entry to its body.
    if (body_start) begin
      st.key_idx = '0;
      if (st.remaining == 64'd0) begin
        res.data   = '0;
        res.opcode = st.opcode;
        res.fin    = st.fin;
        res.first  = 1'b1;
        res.last   = 1'b1;
        res.empty  = 1'b1;
        emit       = 1'b1;
        st.phase   = PhHeader0;
      end else begin
        st.phase     = PhPayload;
        st.bytes_due = 4'd1;
      end
    end
    return emit;
  endfunction

  // Queues one stream byte and tracks where the parser will stand after it.
  task automatic queue_byte(input logic [7:0] b);
    frame_result_t unused;
    stream_bytes_q.push_back(b);
    void'(deframe_byte(gen_parser, b, unused));
  endtask

  // Random filler that keeps any extended length below 256 bytes.
  function automatic logic [7:0] noise_byte();
    if (gen_parser.phase == PhExtLen && gen_parser.bytes_due > 4'd1) begin
      return 8'h00;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Builds one frame; keep < 0 queues it whole, otherwise only its first keep bytes.
  task automatic queue_frame(input logic [7:0] hdr0, input logic masked,
                             input len_form_e form, input logic [63:0] len,
                             input logic [31:0] key, input int fill, input int keep);
    logic [7:0] frame_bytes[$];
    longint unsigned pay_count;
    frame_bytes.push_back(hdr0);
    case (form)
      LenExt16: begin
        frame_bytes.push_back({masked, LenCode16});
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
      end
      LenExt64: begin
        frame_bytes.push_back({masked, LenCode64});
        for (int i = 7; i >= 0; i--) begin
          frame_bytes.push_back(len[8 * i +: 8]);
        end
      end
      default: begin
        frame_bytes.push_back({masked, len[6:0]});
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) begin
        frame_bytes.push_back(key[8 * i +: 8]);
      end
    end
    pay_count = len;
    if (keep >= 0 && pay_count > longint'(keep)) begin
      pay_count = longint'(keep);
    end
    for (longint unsigned i = 0; i < pay_count; i++) begin
      frame_bytes.push_back((fill >= 0) ? 8'(fill) : 8'($urandom_range(0, 255)));
    end
    if (keep >= 0 && frame_bytes.size() > keep) begin
      frame_bytes = frame_bytes[0:keep-1];
    end
    foreach (frame_bytes[i]) begin
      queue_byte(frame_bytes[i]);
    end
    frames_queued++;
  endtask

  function automatic void compare_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      fail_count++;
    end
  endfunction

  // Request driver: predicts each accepted byte, then offers the next one.
  always @(posedge clk_i) begin
    frame_result_t res;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        sent_count++;
        if (deframe_byte(rx_parser, rx_byte_i, res)) begin
          awaited_results_q.push_back(res);
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (stream_bytes_q.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (stream_bytes_q.size() > TailItems && (sent_count / 128) % 3 != 2
                     && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 14) - 1;
          in_valid_i <= 1'b0;
        end else begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= stream_bytes_q.pop_front();
        end
      end
    end
  end

  // Result monitor: checks each accepted result and applies random backpressure.
  always @(posedge clk_i) begin
    frame_result_t exp_res;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_results_q.size() == 0) begin
          $error("unexpected result: payload_byte %0h with nothing awaited", payload_byte_o);
          fail_count++;
        end else begin
          exp_res = awaited_results_q.pop_front();
          compare_field("payload_byte", exp_res.data, payload_byte_o);
          compare_field("frame_opcode", 8'(exp_res.opcode), 8'(frame_opcode_o));
          compare_field("final_fragment", 8'(exp_res.fin), 8'(final_fragment_o));
          compare_field("first_of_frame", 8'(exp_res.first), 8'(first_of_frame_o));
          compare_field("last_of_frame", 8'(exp_res.last), 8'(last_of_frame_o));
          compare_field("empty_frame", 8'(exp_res.empty), 8'(empty_frame_o));
          checked_count++;
          if (exp_res.empty) begin
            empty_count++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else if (stream_bytes_q.size() > TailItems && (checked_count / 96) % 3 != 1
                   && $urandom_range(0, 5) == 0) begin
        out_stall = $urandom_range(1, 14) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned directed_count;
    int unsigned sel;
    logic [7:0]  hdr0;
    logic        masked;
    logic [63:0] len;
    int          keep;
    rx_parser  = parser_at_reset();
    gen_parser = parser_at_reset();

    // Directed frames: empty frames, byte extremes, key extremes, opcode extremes,
    // RSV bits set, and a non-minimal 16-bit length.
    queue_frame(8'h8F, 1'b0, LenShort, 64'd0, 32'h0, -1, -1);
    queue_frame(8'h70, 1'b1, LenShort, 64'd0, 32'h0, -1, -1);
    queue_frame(8'h01, 1'b0, LenShort, 64'd1, 32'h0, 8'hFF, -1);
    queue_frame(8'hF2, 1'b1, LenShort, 64'd3, 32'hFFFF_FFFF, 8'h00, -1);
    queue_frame(8'h09, 1'b0, LenExt16, 64'd1, 32'h0, -1, -1);
    directed_count = stream_bytes_q.size();

    // Mostly well-formed frames with random content; the rest are cut-off frames
    // followed by noise, after which the stream is brought back to a frame start.
    while (stream_bytes_q.size() < directed_count + RandomItems) begin
      sel    = $urandom_range(0, 99);
      hdr0   = 8'($urandom_range(0, 255));
      masked = 1'($urandom_range(0, 1));
      if (sel < 55) begin
        queue_frame(hdr0, masked, LenShort, 64'($urandom_range(0, 12)), $urandom, -1, -1);
      end else if (sel < 67) begin
        len = ($urandom_range(0, 3) == 0) ? 64'd125 : 64'($urandom_range(13, 124));
        queue_frame(hdr0, masked, LenShort, len, $urandom, -1, -1);
      end else if (sel < 77) begin
        queue_frame(hdr0, masked, LenExt16, 64'($urandom_range(0, 300)), $urandom, -1, -1);
      end else if (sel < 85) begin
        queue_frame(hdr0, masked, LenExt64, 64'($urandom_range(0, 40)), $urandom, -1, -1);
      end else begin
        len  = 64'($urandom_range(0, 12));
        keep = $urandom_range(1, 2 + (masked ? 4 : 0) + int'(len));
        queue_frame(hdr0, masked, LenShort, len, $urandom, -1, keep);
        repeat ($urandom_range(1, 6)) queue_byte(noise_byte());
        while (gen_parser.phase != PhHeader0) begin
          queue_byte(noise_byte());
        end
      end
    end

    // A huge 64-bit length with its top bit set: only part of its payload is sent.
    queue_frame(8'h82, 1'b1, LenExt64, {1'b1, 31'($urandom), 32'($urandom)}, $urandom,
                -1, 54);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stream_bytes_q.size() > 0 || in_valid_i || awaited_results_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d stream bytes in %0d frames (directed, random, cut-off, noise, huge).",
             sent_count, frames_queued);
    $display("Checked %0d results, %0d of them empty-frame results, with %0d failures.",
             checked_count, empty_count, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== websocket_frame_deframer_unit.f =====
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_parser.sv
hw/rtl/wsd_fifo.sv
hw/rtl/wsd_emit.sv
hw/rtl/websocket_frame_deframer_unit.sv
hw/rtl/wsd_checker.sv
test/tb_websocket_frame_deframer_unit.sv
